// ----- hdl/cdoa_pkg.sv -----
// Shared widths, codes, types and the month length function of the date offset adder.
package cdoa_pkg;

  localparam int YEAR_W  = 16;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int MVAL_W  = 13;
  localparam int DVAL_W  = 17;
  localparam int ACC_W   = 18;

  localparam int YEAR_MAX_DEF = 65535;

  localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_AUG    = 4'd8;
  localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST    = 5'd1;
  localparam logic [DAY_W-1:0]   DAYS_LONG    = 5'd31;
  localparam logic [DAY_W-1:0]   DAYS_SHORT   = 5'd30;
  localparam logic [DAY_W-1:0]   DAYS_FEB     = 5'd28;
  localparam logic [DAY_W-1:0]   DAYS_FEB_LP  = 5'd29;
  localparam int                 MONTHS_YEAR  = 12;

  typedef enum logic [1:0] {
    KIND_LOAD     = 2'd0,
    KIND_ADD_DAYS = 2'd1,
    KIND_ADD_DATE = 2'd2,
    KIND_SUB_DATE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_DAY,
    ST_OUT
  } state_t;

  // Calendar facts about the working date, produced by the helper unit.
  typedef struct packed {
    logic [DAY_W-1:0]   len_cur;
    logic [DAY_W-1:0]   len_prev;
    logic [YEAR_W-1:0]  year_up;
    logic [YEAR_W-1:0]  year_dn;
    logic               up_sat;
    logic [MONTH_W-1:0] month_up;
    logic [MONTH_W-1:0] month_dn;
    logic               wrap_up;
    logic               wrap_dn;
  } cal_info_t;

  // Every year divisible by four counts as a leap year.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (m == MONTH_FEB) begin
      len = leap ? DAYS_FEB_LP : DAYS_FEB;
    end else if (m >= MONTH_AUG) begin
      len = m[0] ? DAYS_SHORT : DAYS_LONG;
    end else begin
      len = m[0] ? DAYS_LONG : DAYS_SHORT;
    end
    return len;
  endfunction

endpackage

// ----- hdl/cdoa_cal.sv -----
// Calendar helper: month lengths and saturating year and wrapping month steps.
module cdoa_cal #(
  parameter int YEAR_MAX = cdoa_pkg::YEAR_MAX_DEF
) (
  input  logic [cdoa_pkg::YEAR_W-1:0]  year,
  input  logic [cdoa_pkg::MONTH_W-1:0] month,
  output cdoa_pkg::cal_info_t          info
);

  localparam logic [cdoa_pkg::YEAR_W-1:0] YMAX = YEAR_MAX[cdoa_pkg::YEAR_W-1:0];

  logic leap;

  assign leap = (year[1:0] == 2'b00);

  always_comb begin
    info.wrap_up  = (month == cdoa_pkg::MONTH_DEC);
    info.wrap_dn  = (month == cdoa_pkg::MONTH_JAN);
    info.month_up = info.wrap_up ? cdoa_pkg::MONTH_JAN : month + 4'd1;
    info.month_dn = info.wrap_dn ? cdoa_pkg::MONTH_DEC : month - 4'd1;
    info.len_cur  = cdoa_pkg::month_len(month, leap);
    // The month before January is December of the year before, always 31 days,
    // so the year only matters when stepping back from March into February.
    info.len_prev = cdoa_pkg::month_len(info.month_dn, leap);
    info.up_sat   = (year == YMAX);
    info.year_up  = info.up_sat ? YMAX : year + 16'd1;
    info.year_dn  = (year == '0) ? '0 : year - 16'd1;
  end

endmodule

// ----- hdl/calendar_date_offset_adder.sv -----
// Top level of the calendar date offset adder: sequencer around one shared accumulator adder.
// The accumulator folds one year of months or one month of days per cycle; a day offset skips
// the year and month steps, and a date offset runs the normalization twice (operand, then
// current date).
// Throughput: one word at a time; in_ready is low from acceptance until the result is queued.
// Reset: the date returns to year 0, January 1st, the sequencer idles, no result is pending.
module calendar_date_offset_adder #(
  parameter int YEAR_MAX = cdoa_pkg::YEAR_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_kind,
  input  logic signed [cdoa_pkg::YEAR_W-1:0]  in_year_value,
  input  logic signed [cdoa_pkg::MVAL_W-1:0]  in_month_value,
  input  logic signed [cdoa_pkg::DVAL_W-1:0]  in_day_value,
  input  logic signed [cdoa_pkg::DVAL_W-1:0]  in_day_offset,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cdoa_pkg::YEAR_W-1:0]         out_year,
  output logic [cdoa_pkg::MONTH_W-1:0]        out_month,
  output logic [cdoa_pkg::DAY_W-1:0]          out_day,
  output logic                                out_year_saturated
);

  localparam int AW = cdoa_pkg::ACC_W;
  localparam int YW = cdoa_pkg::YEAR_W;
  localparam int MW = cdoa_pkg::MONTH_W;
  localparam int DW = cdoa_pkg::DAY_W;
  localparam logic [YW-1:0] YMAX = YEAR_MAX[YW-1:0];

  // The working date (w_*) is the block's current date. The o_* registers first hold a
  // saved copy of the current date while a date offset operand is normalized in w_*,
  // and after the swap they hold the normalized operand.
  cdoa_pkg::state_t state_r, state_nxt;
  cdoa_pkg::kind_t  kind_r, kind_nxt;
  logic             opd_r, opd_nxt;
  logic             sat_r, sat_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic [YW-1:0] w_y_r, w_y_nxt, o_y_r, o_y_nxt;
  logic [MW-1:0] w_m_r, w_m_nxt, o_m_r, o_m_nxt;
  logic [DW-1:0] w_d_r, w_d_nxt, o_d_r, o_d_nxt;
  logic signed [cdoa_pkg::MVAL_W-1:0] mv_r, mv_nxt;
  logic signed [cdoa_pkg::DVAL_W-1:0] dv_r, dv_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [YW-1:0] out_y_r, out_y_nxt;
  logic [MW-1:0] out_m_r, out_m_nxt;
  logic [DW-1:0] out_d_r, out_d_nxt;
  logic          out_s_r, out_s_nxt;

  // The shared unit: one adder with an optional negation of the second operand.
  logic signed [AW-1:0] op_a, op_b, sum;
  logic                 op_neg;

  cdoa_pkg::cal_info_t info;

  logic load_phase;
  logic is_sub;
  logic acc_le0, acc_gt12, acc_gt_len, acc_gt_ymax;

  cdoa_cal #(.YEAR_MAX(YEAR_MAX)) u_cal (
    .year  (w_y_r),
    .month (w_m_r),
    .info  (info)
  );

  assign sum = op_a + (op_b ^ {AW{op_neg}}) + AW'(op_neg);

  // A plain load, or the operand pass of a date offset, takes the captured fields.
  assign load_phase  = (kind_r == cdoa_pkg::KIND_LOAD) || opd_r;
  assign is_sub      = (kind_r == cdoa_pkg::KIND_SUB_DATE);
  assign acc_le0     = (acc_r <= 0);
  assign acc_gt12    = (acc_r > $signed(AW'(cdoa_pkg::MONTHS_YEAR)));
  assign acc_gt_len  = (acc_r > $signed(AW'(info.len_cur)));
  assign acc_gt_ymax = (acc_r > $signed(AW'(YMAX)));

  assign in_ready           = (state_r == cdoa_pkg::ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_year           = out_y_r;
  assign out_month          = out_m_r;
  assign out_day            = out_d_r;
  assign out_year_saturated = out_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdoa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      w_y_r       <= '0;
      w_m_r       <= cdoa_pkg::MONTH_JAN;
      w_d_r       <= cdoa_pkg::DAY_FIRST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      w_y_r       <= w_y_nxt;
      w_m_r       <= w_m_nxt;
      w_d_r       <= w_d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    opd_r   <= opd_nxt;
    sat_r   <= sat_nxt;
    acc_r   <= acc_nxt;
    o_y_r   <= o_y_nxt;
    o_m_r   <= o_m_nxt;
    o_d_r   <= o_d_nxt;
    mv_r    <= mv_nxt;
    dv_r    <= dv_nxt;
    out_y_r <= out_y_nxt;
    out_m_r <= out_m_nxt;
    out_d_r <= out_d_nxt;
    out_s_r <= out_s_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    opd_nxt       = opd_r;
    sat_nxt       = sat_r;
    acc_nxt       = acc_r;
    w_y_nxt       = w_y_r;
    w_m_nxt       = w_m_r;
    w_d_nxt       = w_d_r;
    o_y_nxt       = o_y_r;
    o_m_nxt       = o_m_r;
    o_d_nxt       = o_d_r;
    mv_nxt        = mv_r;
    dv_nxt        = dv_r;
    out_y_nxt     = out_y_r;
    out_m_nxt     = out_m_r;
    out_d_nxt     = out_d_r;
    out_s_nxt     = out_s_r;
    out_valid_nxt = out_valid_r && !out_ready;
    op_a          = acc_r;
    op_b          = '0;
    op_neg        = 1'b0;

    unique case (state_r)
      cdoa_pkg::ST_IDLE: begin
        if (in_valid) begin
          kind_nxt = cdoa_pkg::kind_t'(in_kind);
          mv_nxt   = in_month_value;
          dv_nxt   = in_day_value;
          sat_nxt  = 1'b0;
          o_y_nxt  = w_y_r;
          o_m_nxt  = w_m_r;
          o_d_nxt  = w_d_r;
          if (cdoa_pkg::kind_t'(in_kind) == cdoa_pkg::KIND_ADD_DAYS) begin
            op_a      = $signed(AW'(w_d_r));
            op_b      = AW'(in_day_offset);
            opd_nxt   = 1'b0;
            state_nxt = cdoa_pkg::ST_DAY;
          end else begin
            op_a      = AW'(in_year_value);
            opd_nxt   = (in_kind[1] == 1'b1);
            state_nxt = cdoa_pkg::ST_YEAR;
          end
          acc_nxt = sum;
        end
      end

      cdoa_pkg::ST_YEAR: begin
        priority if (acc_le0) begin
          w_y_nxt = '0;
        end else if (acc_gt_ymax) begin
          w_y_nxt = YMAX;
          sat_nxt = 1'b1;
        end else begin
          w_y_nxt = acc_r[YW-1:0];
        end
        // Set up the month value to normalize next.
        if (load_phase) begin
          op_a = AW'(mv_r);
        end else begin
          op_a   = $signed(AW'(w_m_r));
          op_b   = $signed(AW'(o_m_r));
          op_neg = is_sub;
        end
        acc_nxt   = sum;
        state_nxt = cdoa_pkg::ST_MONTH;
      end

      cdoa_pkg::ST_MONTH: begin
        priority if (acc_gt12) begin
          op_b    = $signed(AW'(cdoa_pkg::MONTHS_YEAR));
          op_neg  = 1'b1;
          acc_nxt = sum;
          w_y_nxt = info.year_up;
          sat_nxt = sat_r | info.up_sat;
        end else if (acc_le0) begin
          op_b    = $signed(AW'(cdoa_pkg::MONTHS_YEAR));
          acc_nxt = sum;
          w_y_nxt = info.year_dn;
        end else begin
          w_m_nxt = acc_r[MW-1:0];
          if (load_phase) begin
            op_a = AW'(dv_r);
          end else begin
            op_a   = $signed(AW'(w_d_r));
            op_b   = $signed(AW'(o_d_r));
            op_neg = is_sub;
          end
          acc_nxt   = sum;
          state_nxt = cdoa_pkg::ST_DAY;
        end
      end

      cdoa_pkg::ST_DAY: begin
        priority if (acc_gt_len) begin
          // Remove this month's length, then move on one month.
          op_b    = $signed(AW'(info.len_cur));
          op_neg  = 1'b1;
          acc_nxt = sum;
          w_m_nxt = info.month_up;
          if (info.wrap_up) begin
            w_y_nxt = info.year_up;
            sat_nxt = sat_r | info.up_sat;
          end
        end else if (acc_le0) begin
          // Step back one month and add the length of that earlier month.
          op_b    = $signed(AW'(info.len_prev));
          acc_nxt = sum;
          w_m_nxt = info.month_dn;
          if (info.wrap_dn) begin
            w_y_nxt = info.year_dn;
          end
        end else if (opd_r) begin
          // Operand done: swap it with the saved current date and start on the year.
          o_y_nxt   = w_y_r;
          o_m_nxt   = w_m_r;
          o_d_nxt   = acc_r[DW-1:0];
          w_y_nxt   = o_y_r;
          w_m_nxt   = o_m_r;
          w_d_nxt   = o_d_r;
          op_a      = $signed(AW'(o_y_r));
          op_b      = $signed(AW'(w_y_r));
          op_neg    = is_sub;
          acc_nxt   = sum;
          opd_nxt   = 1'b0;
          state_nxt = cdoa_pkg::ST_YEAR;
        end else begin
          w_d_nxt   = acc_r[DW-1:0];
          state_nxt = cdoa_pkg::ST_OUT;
        end
      end

      cdoa_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_y_nxt     = w_y_r;
          out_m_nxt     = w_m_r;
          out_d_nxt     = w_d_r;
          out_s_nxt     = sat_r;
          out_valid_nxt = 1'b1;
          state_nxt     = cdoa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = cdoa_pkg::ST_IDLE;
      end
    endcase
  end

  // The working month always lies in January..December.
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (w_m_r >= cdoa_pkg::MONTH_JAN) && (w_m_r <= cdoa_pkg::MONTH_DEC))
    else $error("working month out of range");

  // The working year never passes the configured maximum.
  a_year_max: assert property (@(posedge clk) disable iff (!rst_n) w_y_r <= YMAX)
    else $error("working year above maximum");

  // A delivered date is a real calendar date.
  a_out_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_m_r >= cdoa_pkg::MONTH_JAN) && (out_m_r <= cdoa_pkg::MONTH_DEC) &&
                    (out_d_r >= cdoa_pkg::DAY_FIRST) &&
                    (out_d_r <= cdoa_pkg::month_len(out_m_r, out_y_r[1:0] == 2'b00)))
    else $error("result date not normalized");

  // Accepting a word makes the block busy on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready after acceptance");

endmodule

// ----- tb/calendar_date_offset_adder_tb.sv -----
// Self-checking testbench of the calendar date offset adder: random and directed words.
`timescale 1ns / 1ps

module calendar_date_offset_adder_tb;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_WORDS = 400;
  // The last words go out with no idling on either side.
  localparam int QUIET_TAIL   = 40;
  // Every word gives exactly one result, so once the last result is in, the block should
  // stay silent; this window catches a stray result after the end.
  localparam int DRAIN_CYCLES = 64;
  // The slowest word folds about 340 years of months and about 2200 months of days once;
  // 425 such words with the longest gaps and stalls still stay far below this limit.
  localparam int TIMEOUT_NS   = 100_000_000;
  localparam int YEAR_LIMIT   = cdoa_pkg::YEAR_MAX_DEF;

  // One input word as it is queued for the driver. The drain flag holds the word back until
  // every result of the earlier words has been taken.
  typedef struct packed {
    cdoa_pkg::kind_t                     kind;
    logic signed [cdoa_pkg::YEAR_W-1:0]  year_value;
    logic signed [cdoa_pkg::MVAL_W-1:0]  month_value;
    logic signed [cdoa_pkg::DVAL_W-1:0]  day_value;
    logic signed [cdoa_pkg::DVAL_W-1:0]  day_offset;
    logic                                drain;
  } date_word_t;

  // The date the block must return for one word.
  typedef struct packed {
    logic [cdoa_pkg::YEAR_W-1:0]  year;
    logic [cdoa_pkg::MONTH_W-1:0] month;
    logic [cdoa_pkg::DAY_W-1:0]   day;
    logic                         saturated;
  } date_result_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [1:0]                          in_kind = cdoa_pkg::KIND_LOAD;
  logic signed [cdoa_pkg::YEAR_W-1:0]  in_year_value = '0;
  logic signed [cdoa_pkg::MVAL_W-1:0]  in_month_value = '0;
  logic signed [cdoa_pkg::DVAL_W-1:0]  in_day_value = '0;
  logic signed [cdoa_pkg::DVAL_W-1:0]  in_day_offset = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [cdoa_pkg::YEAR_W-1:0]         out_year;
  logic [cdoa_pkg::MONTH_W-1:0]        out_month;
  logic [cdoa_pkg::DAY_W-1:0]          out_day;
  logic                                out_year_saturated;

  date_word_t   pending_words[$];
  date_result_t expected_dates[$];
  date_word_t   on_wire;
  date_result_t due;

  // The predicted date register, plus a scratch date that the normalization works on.
  int now_y = 0;
  int now_m = 1;
  int now_d = 1;
  int work_y, work_m, work_d;
  bit step_sat;

  int total_words = 0;
  int words_sent = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit quiet = 1'b0;
  bit failed = 1'b0;

  calendar_date_offset_adder dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_year_value      (in_year_value),
    .in_month_value     (in_month_value),
    .in_day_value       (in_day_value),
    .in_day_offset      (in_day_offset),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_year           (out_year),
    .out_month          (out_month),
    .out_day            (out_day),
    .out_year_saturated (out_year_saturated)
  );

  always #HALF_PERIOD clk = ~clk;

  // Any year at or below zero becomes year 0; a year past the limit is held there and flagged.
  function automatic void set_year(input int v);
    if (v <= 0) begin
      work_y = 0;
    end else if (v > YEAR_LIMIT) begin
      work_y = YEAR_LIMIT;
      step_sat = 1'b1;
    end else begin
      work_y = v;
    end
  endfunction

  // Length of the scratch month. Every fourth year is a leap year, with no century rule.
  function automatic int month_days();
    int len;
    if (work_m == cdoa_pkg::MONTH_FEB) begin
      len = (work_y % 4 == 0) ? 29 : 28;
    end else if (work_m >= cdoa_pkg::MONTH_AUG) begin
      len = (work_m % 2 == 0) ? 31 : 30;
    end else begin
      len = (work_m % 2 == 1) ? 31 : 30;
    end
    return len;
  endfunction

  // Months outside 1..12 carry or borrow one year at a time.
  function automatic void set_month(input int v);
    while (v > cdoa_pkg::MONTHS_YEAR || v <= 0) begin
      if (v > cdoa_pkg::MONTHS_YEAR) begin
        set_year(work_y + 1);
        v -= cdoa_pkg::MONTHS_YEAR;
      end else begin
        set_year(work_y - 1);
        v += cdoa_pkg::MONTHS_YEAR;
      end
    end
    work_m = v;
  endfunction

  // Days outside the month carry or borrow one month at a time. On a carry the length of the
  // month being left is taken off; on a borrow the length of the month entered is added.
  function automatic void set_day(input int v);
    while (v > month_days() || v <= 0) begin
      if (v > month_days()) begin
        v -= month_days();
        set_month(work_m + 1);
      end else begin
        set_month(work_m - 1);
        v += month_days();
      end
    end
    work_d = v;
  endfunction

  function automatic void settle_date(input int y, input int m, input int d);
    set_year(y);
    set_month(m);
    set_day(d);
  endfunction

  // Applies one accepted word to the predicted date and queues the date it must produce.
  function automatic void advance_date(input date_word_t w);
    int opd_y, opd_m, opd_d;
    date_result_t r;
    step_sat = 1'b0;
    opd_y = 0;
    opd_m = 0;
    opd_d = 0;
    // A date offset is first normalized on its own, starting from year 0, January 1st.
    // Saturation met there counts for the whole word.
    if (w.kind == cdoa_pkg::KIND_ADD_DATE || w.kind == cdoa_pkg::KIND_SUB_DATE) begin
      work_y = 0;
      work_m = 1;
      work_d = 1;
      settle_date(int'(w.year_value), int'(w.month_value), int'(w.day_value));
      opd_y = (w.kind == cdoa_pkg::KIND_SUB_DATE) ? -work_y : work_y;
      opd_m = (w.kind == cdoa_pkg::KIND_SUB_DATE) ? -work_m : work_m;
      opd_d = (w.kind == cdoa_pkg::KIND_SUB_DATE) ? -work_d : work_d;
    end
    work_y = now_y;
    work_m = now_m;
    work_d = now_d;
    case (w.kind)
      cdoa_pkg::KIND_LOAD: begin
        settle_date(int'(w.year_value), int'(w.month_value), int'(w.day_value));
      end
      cdoa_pkg::KIND_ADD_DAYS: begin
        set_day(work_d + int'(w.day_offset));
      end
      default: begin
        // Year, then month, then day, each normalized before the next is applied.
        set_year(work_y + opd_y);
        set_month(work_m + opd_m);
        set_day(work_d + opd_d);
      end
    endcase
    now_y = work_y;
    now_m = work_m;
    now_d = work_d;
    r.year = now_y[cdoa_pkg::YEAR_W-1:0];
    r.month = now_m[cdoa_pkg::MONTH_W-1:0];
    r.day = now_d[cdoa_pkg::DAY_W-1:0];
    r.saturated = step_sat;
    expected_dates.push_back(r);
  endfunction

  function automatic void queue_word(input cdoa_pkg::kind_t k, input int y, input int m,
                                     input int d, input int off, input bit drain);
    date_word_t w;
    w.kind = k;
    w.year_value = y[cdoa_pkg::YEAR_W-1:0];
    w.month_value = m[cdoa_pkg::MVAL_W-1:0];
    w.day_value = d[cdoa_pkg::DVAL_W-1:0];
    w.day_offset = off[cdoa_pkg::DVAL_W-1:0];
    w.drain = drain;
    pending_words.push_back(w);
  endfunction

  // Mostly a small value around zero; now and then any value the field can hold, which is
  // what makes every bit of the field take both values.
  function automatic int pick_value(input int width, input int span);
    int v;
    if ($urandom_range(0, 15) == 0) begin
      v = int'($urandom_range(0, (1 << width) - 1)) - (1 << (width - 1));
    end else begin
      v = int'($urandom_range(0, 2 * span)) - span;
    end
    return v;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      failed = 1'b1;
    end
  endtask

  // Driver. A word is handed over at the edge where valid and ready are both high; the
  // prediction is made at that same edge from the word still on the pins. The next word,
  // or an idle burst, follows only once the current word has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        advance_date(on_wire);
        words_sent++;
      end
      quiet = pending_words.size() < QUIET_TAIL;
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0 &&
                     !(pending_words[0].drain && expected_dates.size() != 0)) begin
          on_wire = pending_words.pop_front();
          in_valid <= 1'b1;
          in_kind <= on_wire.kind;
          in_year_value <= on_wire.year_value;
          in_month_value <= on_wire.month_value;
          in_day_value <= on_wire.day_value;
          in_day_offset <= on_wire.day_offset;
          if (!quiet && $urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each result taken is matched against the oldest predicted date. Ready drops in
  // random bursts that are independent of the block's progress, so stalls land on every phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_dates.size() == 0) begin
          $display("%0t ns: result with no word outstanding, expected none, actual %0d-%0d-%0d",
                   $time, out_year, out_month, out_day);
          failed = 1'b1;
        end else begin
          due = expected_dates.pop_front();
          check_field("year", int'(due.year), int'(out_year));
          check_field("month", int'(due.month), int'(out_month));
          check_field("day", int'(due.day), int'(out_day));
          check_field("year_saturated", int'(due.saturated), int'(out_year_saturated));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 10);
        end
      end
    end
  end

  initial begin
    int pick;
    int y;
    cdoa_pkg::kind_t k;

    // Directed words. The first two start from the reset date: a zero day offset, then a
    // borrow at year 0, where the year stays at 0 and the month wraps to December.
    queue_word(cdoa_pkg::KIND_ADD_DAYS, 0, 0, 0, 0, 1'b0);
    queue_word(cdoa_pkg::KIND_ADD_DAYS, -1, -1, -1, -1, 1'b0);
    // February 29th in a leap year, then in a common year where it rolls into March.
    queue_word(cdoa_pkg::KIND_LOAD, 2024, 2, 29, 0, 1'b0);
    queue_word(cdoa_pkg::KIND_LOAD, 2023, 2, 29, 0, 1'b0);
    // The most negative and the most positive value of every field.
    queue_word(cdoa_pkg::KIND_LOAD, -32768, -4096, -65536, -65536, 1'b0);
    queue_word(cdoa_pkg::KIND_LOAD, 32767, 4095, 65535, 65535, 1'b0);
    queue_word(cdoa_pkg::KIND_ADD_DAYS, 0, 0, 0, 65535, 1'b0);
    queue_word(cdoa_pkg::KIND_ADD_DAYS, 0, 0, 0, -65536, 1'b0);
    // Month 13 carries a year; day 0 then borrows back into December of the year before.
    queue_word(cdoa_pkg::KIND_LOAD, 2000, 13, 0, 0, 1'b0);
    queue_word(cdoa_pkg::KIND_LOAD, -1, 0, 0, 0, 1'b0);
    // Month ends on both sides of the July/August switch in the length pattern.
    queue_word(cdoa_pkg::KIND_LOAD, 1999, 7, 31, 0, 1'b0);
    queue_word(cdoa_pkg::KIND_LOAD, 1999, 8, 31, 0, 1'b0);
    queue_word(cdoa_pkg::KIND_LOAD, 1999, 9, 31, 0, 1'b0);
    // Year end, then one day more; this word also waits until every earlier result is taken.
    queue_word(cdoa_pkg::KIND_LOAD, 2024, 12, 31, 0, 1'b0);
    queue_word(cdoa_pkg::KIND_ADD_DAYS, 0, 0, 0, 1, 1'b1);
    // A zero date offset is itself normalized first, which borrows at year 0.
    queue_word(cdoa_pkg::KIND_ADD_DATE, 0, 0, 0, 0, 1'b0);
    // Climb to the year limit and past it, including a month carry at the limit.
    queue_word(cdoa_pkg::KIND_LOAD, 32767, 12, 31, 0, 1'b0);
    queue_word(cdoa_pkg::KIND_ADD_DATE, 32767, 12, 31, 0, 1'b0);
    queue_word(cdoa_pkg::KIND_ADD_DATE, 32767, 4095, 65535, 0, 1'b0);
    queue_word(cdoa_pkg::KIND_ADD_DAYS, 0, 0, 0, 400, 1'b0);
    // Subtraction: a huge offset down to year 0, a negative operand, and the minimal one.
    queue_word(cdoa_pkg::KIND_SUB_DATE, 32767, 4095, 65535, 0, 1'b0);
    queue_word(cdoa_pkg::KIND_LOAD, 1500, 6, 15, 0, 1'b0);
    queue_word(cdoa_pkg::KIND_SUB_DATE, -1, -1, -1, 0, 1'b0);
    queue_word(cdoa_pkg::KIND_SUB_DATE, 0, 1, 1, 0, 1'b0);
    queue_word(cdoa_pkg::KIND_SUB_DATE, -32768, -4096, -65536, 0, 1'b0);

    // Random words. Loads keep pulling the date back into a normal range so that the adds
    // and subtracts work on many different months and leap years, not only on the limits.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 5) begin
        k = cdoa_pkg::KIND_LOAD;
      end else if (pick < 12) begin
        k = cdoa_pkg::KIND_ADD_DAYS;
      end else if (pick < 16) begin
        k = cdoa_pkg::KIND_ADD_DATE;
      end else begin
        k = cdoa_pkg::KIND_SUB_DATE;
      end
      case ($urandom_range(0, 3))
        0: y = int'($urandom_range(0, 65535)) - 32768;
        1, 2: y = $urandom_range(0, 3000);
        default: y = int'($urandom_range(0, 10)) - 5;
      endcase
      queue_word(k, y, pick_value(cdoa_pkg::MVAL_W, 14), pick_value(cdoa_pkg::DVAL_W, 40),
                 pick_value(cdoa_pkg::DVAL_W, 400), $urandom_range(0, 39) == 0);
    end
    total_words = pending_words.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Sent count and predictions change together in the driver, so this cannot see a
    // half-updated picture.
    while (words_sent < total_words || expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failed) begin
      $display("[calendar_date_offset_adder] ERROR");
    end else begin
      $display("[calendar_date_offset_adder] OK");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("%0t ns: timeout with %0d words sent and %0d results outstanding",
             $time, words_sent, expected_dates.size());
    $display("[calendar_date_offset_adder] ERROR");
    $finish;
  end

endmodule
